// ===== sv/cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbb_pkg
// Widths, constants and helper functions for the cylinder bounding box unit.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int DW  = CW + 1;        // axis difference width
  localparam int NB  = 23;            // normalized magnitude bit length
  localparam int VW  = NB + 1;        // normalized component, signed
  localparam int MW  = NB;            // normalized component magnitude
  localparam int XW  = 2 * MW + 1;    // cross product magnitude
  localparam int LZW = 6;             // bit length code width
  localparam int SQW = 2 * MW;        // square of a component
  localparam int L2W = SQW + 2;       // sum of three squares
  localparam int LW  = L2W / 2;       // square root width
  localparam int UB  = 24;            // unit vector fraction bits
  localparam int QW  = UB + 1;        // unit component width
  localparam int RW  = CW - 1;        // radius width
  localparam int RHW = RW - UB;       // radius high part width
  localparam int OW  = CW + 1;        // offset width
  localparam int SW  = CW + 2;        // corner sum width

  localparam logic [15:0] COS2_Q16 = 16'd64883;

  typedef struct packed {
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic [RW-1:0]      rad;
    logic               zero;
  } side_t;

  function automatic logic [LZW-1:0] bitlen(input logic [XW-1:0] x);
    logic [LZW-1:0] r;
    r = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) r = LZW'(i + 1);
    end
    return r;
  endfunction

  function automatic logic signed [VW-1:0] norm_comp(input logic s, input logic [XW-1:0] m,
                                                      input logic [LZW-1:0] l);
    logic [XW-1:0] t;
    logic [VW-1:0] r;
    if (int'(l) < NB) t = m << (NB - int'(l));
    else t = m >> (int'(l) - NB);
    r = {1'b0, t[MW-1:0]};
    return s ? -r : r;
  endfunction

  function automatic logic [MW-1:0] mag_v(input logic signed [VW-1:0] v);
    logic [VW-1:0] t;
    t = v[VW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
    if (v[SW-1:CW-1] == '0 || v[SW-1:CW-1] == '1) return v[CW-1:0];
    else if (v[SW-1]) return {1'b1, {(CW-1){1'b0}}};
    else return {1'b0, {(CW-1){1'b1}}};
  endfunction

endpackage

// ===== sv/cylinder_bounding_box_unit.sv =====
// ----------------------------------------------------------------------------
// cylinder_bounding_box_unit
// Approximate axis-aligned box of a cylinder given its axis end points and
// radius, in signed Q16.16. The axis is normalized, two radial vectors are
// built by cross products, scaled to the radius, and the box is grown around
// both end points and saturated. A zero-length axis sets zero_axis and gives
// the bare end point. The unit takes one item every cycle while the output
// does not stall; the pipeline depth is set by the 24-stage square root and
// the 25-stage divider that make the radial unit vectors. Stall from the
// output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module cylinder_bounding_box_unit
  import cbb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] start_z_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic signed [CW-1:0] end_z_i,
  input  logic [RW-1:0]        cyl_radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [CW-1:0] min_x_o,
  output logic signed [CW-1:0] min_y_o,
  output logic signed [CW-1:0] min_z_o,
  output logic signed [CW-1:0] max_x_o,
  output logic signed [CW-1:0] max_y_o,
  output logic signed [CW-1:0] max_z_o,
  output logic                 zero_axis_o
);

  localparam int SQ0 = 15;
  localparam int DP  = SQ0 + LW;
  localparam int DV0 = DP + 1;
  localparam int ML  = DV0 + QW;
  localparam int NS  = ML + 4;

  logic  en;
  logic  v_q  [NS];
  side_t sd_q [NS];
  side_t sd_d;

  assign en          = ~(out_valid_o & out_stall_i);
  assign in_stall_o  = ~en;
  assign out_valid_o = v_q[NS-1];

  logic signed [CW-1:0] ia [3];
  logic signed [CW-1:0] ib [3];
  logic signed [DW-1:0] df0 [3];

  assign ia[0] = start_x_i;
  assign ia[1] = start_y_i;
  assign ia[2] = start_z_i;
  assign ib[0] = end_x_i;
  assign ib[1] = end_y_i;
  assign ib[2] = end_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df0[i]       = DW'(ib[i]) - DW'(ia[i]);
      sd_d.lo[i]   = (ia[i] < ib[i]) ? ia[i] : ib[i];
      sd_d.hi[i]   = (ia[i] < ib[i]) ? ib[i] : ia[i];
    end
    sd_d.rad  = cyl_radius_i;
    sd_d.zero = (df0[0] == '0) && (df0[1] == '0) && (df0[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_d;
      for (int i = 1; i < NS; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // axis direction, normalize, near-x test, first radial vector
  logic                 ns0_q [3];
  logic [DW-1:0]        nm0_q [3];
  logic                 ns1_q [3];
  logic [DW-1:0]        nm1_q [3];
  logic [LZW-1:0]       l1_q;
  logic signed [VW-1:0] n2_q [3];
  logic signed [VW-1:0] n3_q [3];
  logic [SQW-1:0]       sq3_q [3];
  logic signed [VW-1:0] n4_q [3];
  logic [L2W-1:0]       l2_4_q;
  logic [SQW+15:0]      lhs4_q;
  logic signed [VW-1:0] n5_q [3];
  logic [SQW+15:0]      lhs5_q;
  logic [63:0]          cp5_q;
  logic signed [VW-1:0] n6_q [3];
  logic                 r1s6_q [3];
  logic [MW-1:0]        r1m6_q [3];
  logic signed [VW-1:0] n7_q [3];
  logic                 r1s7_q [3];
  logic [MW-1:0]        r1m7_q [3];
  logic [LZW-1:0]       l7_q;
  logic signed [VW-1:0] n8_q [3];
  logic signed [VW-1:0] r1_8_q [3];
  logic                 near6;

  assign near6 = {2'b00, lhs5_q} > cp5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ns0_q[i] <= df0[i][DW-1];
        nm0_q[i] <= df0[i][DW-1] ? DW'(-df0[i]) : DW'(df0[i]);
        ns1_q[i] <= ns0_q[i];
        nm1_q[i] <= nm0_q[i];
        n2_q[i]  <= norm_comp(ns1_q[i], XW'(nm1_q[i]), l1_q);
        n3_q[i]  <= n2_q[i];
        sq3_q[i] <= SQW'(mag_v(n2_q[i])) * SQW'(mag_v(n2_q[i]));
        n4_q[i]  <= n3_q[i];
        n5_q[i]  <= n4_q[i];
        n6_q[i]  <= n5_q[i];
        n7_q[i]  <= n6_q[i];
        n8_q[i]  <= n7_q[i];
        r1s7_q[i] <= r1s6_q[i];
        r1m7_q[i] <= r1m6_q[i];
        r1_8_q[i] <= norm_comp(r1s7_q[i], XW'(r1m7_q[i]), l7_q);
      end
      l1_q   <= bitlen(XW'(nm0_q[0] | nm0_q[1] | nm0_q[2]));
      l2_4_q <= L2W'(sq3_q[0]) + L2W'(sq3_q[1]) + L2W'(sq3_q[2]);
      lhs4_q <= {sq3_q[0], 16'h0000};
      lhs5_q <= lhs4_q;
      cp5_q  <= 64'(COS2_Q16) * 64'(l2_4_q);
      if (near6) begin
        r1s6_q[0] <= n5_q[2][VW-1];
        r1m6_q[0] <= mag_v(n5_q[2]);
        r1s6_q[1] <= 1'b0;
        r1m6_q[1] <= '0;
        r1s6_q[2] <= ~n5_q[0][VW-1] & (n5_q[0] != '0);
        r1m6_q[2] <= mag_v(n5_q[0]);
      end else begin
        r1s6_q[0] <= 1'b0;
        r1m6_q[0] <= '0;
        r1s6_q[1] <= ~n5_q[2][VW-1] & (n5_q[2] != '0);
        r1m6_q[1] <= mag_v(n5_q[2]);
        r1s6_q[2] <= n5_q[1][VW-1];
        r1m6_q[2] <= mag_v(n5_q[1]);
      end
      l7_q <= bitlen(XW'(r1m6_q[0] | r1m6_q[1] | r1m6_q[2]));
    end
  end

  // second radial vector
  logic signed [2*VW-1:0] p9_q [6];
  logic signed [VW-1:0]   r1_9_q [3];
  logic signed [VW-1:0]   r1_10_q [3];
  logic                   r2s10_q [3];
  logic [XW-1:0]          r2m10_q [3];
  logic signed [VW-1:0]   r1_11_q [3];
  logic                   r2s11_q [3];
  logic [XW-1:0]          r2m11_q [3];
  logic [LZW-1:0]         l11_q;
  logic signed [VW-1:0]   r1_12_q [3];
  logic signed [VW-1:0]   r2_12_q [3];
  logic signed [2*VW:0]   dif10 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif10[i] = $signed({p9_q[2*i][2*VW-1], p9_q[2*i]})
               - $signed({p9_q[2*i+1][2*VW-1], p9_q[2*i+1]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_q[0] <= r1_8_q[1] * n8_q[2];
      p9_q[1] <= r1_8_q[2] * n8_q[1];
      p9_q[2] <= r1_8_q[2] * n8_q[0];
      p9_q[3] <= r1_8_q[0] * n8_q[2];
      p9_q[4] <= r1_8_q[0] * n8_q[1];
      p9_q[5] <= r1_8_q[1] * n8_q[0];
      for (int i = 0; i < 3; i++) begin
        r1_9_q[i]  <= r1_8_q[i];
        r1_10_q[i] <= r1_9_q[i];
        r2s10_q[i] <= dif10[i][2*VW];
        r2m10_q[i] <= dif10[i][2*VW] ? XW'(-dif10[i]) : XW'(dif10[i]);
        r1_11_q[i] <= r1_10_q[i];
        r2s11_q[i] <= r2s10_q[i];
        r2m11_q[i] <= r2m10_q[i];
        r1_12_q[i] <= r1_11_q[i];
        r2_12_q[i] <= norm_comp(r2s11_q[i], r2m11_q[i], l11_q);
      end
      l11_q <= bitlen(r2m10_q[0] | r2m10_q[1] | r2m10_q[2]);
    end
  end

  // lengths of both radial vectors
  logic [MW-1:0]  vm13_q [6];
  logic [SQW-1:0] vsq13_q [6];
  logic [MW-1:0]  vm14_q [6];
  logic [L2W-1:0] l2_14_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vm13_q[i]    <= mag_v(r1_12_q[i]);
        vm13_q[3+i]  <= mag_v(r2_12_q[i]);
        vsq13_q[i]   <= SQW'(mag_v(r1_12_q[i])) * SQW'(mag_v(r1_12_q[i]));
        vsq13_q[3+i] <= SQW'(mag_v(r2_12_q[i])) * SQW'(mag_v(r2_12_q[i]));
      end
      for (int j = 0; j < 6; j++) vm14_q[j] <= vm13_q[j];
      l2_14_q[0] <= L2W'(vsq13_q[0]) + L2W'(vsq13_q[1]) + L2W'(vsq13_q[2]);
      l2_14_q[1] <= L2W'(vsq13_q[3]) + L2W'(vsq13_q[4]) + L2W'(vsq13_q[5]);
    end
  end

  // square root, one result bit per stage
  logic [L2W-1:0] sx_q [LW][2];
  logic [L2W+1:0] sr_q [LW][2];
  logic [MW-1:0]  svm_q [LW][6];
  logic [L2W-1:0] sx_d [LW][2];
  logic [L2W+1:0] sr_d [LW][2];

  always_comb begin
    logic [L2W-1:0] xin;
    logic [L2W+1:0] rin;
    logic [L2W+1:0] bitv;
    logic [L2W+1:0] ts;
    for (int s = 0; s < LW; s++) begin
      for (int v = 0; v < 2; v++) begin
        xin  = (s == 0) ? l2_14_q[v] : sx_q[(s == 0) ? 0 : s-1][v];
        rin  = (s == 0) ? '0 : sr_q[(s == 0) ? 0 : s-1][v];
        bitv = (L2W+2)'(1) << (2 * (LW - 1 - s));
        ts   = rin + bitv;
        if ({2'b00, xin} >= ts) begin
          sx_d[s][v] = xin - ts[L2W-1:0];
          sr_d[s][v] = (rin >> 1) + bitv;
        end else begin
          sx_d[s][v] = xin;
          sr_d[s][v] = rin >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < LW; s++) begin
        for (int v = 0; v < 2; v++) begin
          sx_q[s][v] <= sx_d[s][v];
          sr_q[s][v] <= sr_d[s][v];
        end
        for (int j = 0; j < 6; j++) begin
          svm_q[s][j] <= (s == 0) ? vm14_q[j] : svm_q[(s == 0) ? 0 : s-1][j];
        end
      end
    end
  end

  // divider setup and restoring division, one quotient bit per stage
  logic [LW-1:0]    len_dp [2];
  logic [UB+MW:0]   dvd_dp [6];
  logic [LW-1:0]    dl_q [2];
  logic [LW-1:0]    drem_q [6];
  logic [QW-1:0]    dlo_q [6];
  logic [LW-1:0]    qd_q [QW][2];
  logic [LW-1:0]    qr_q [QW][6];
  logic [QW-1:0]    ql_q [QW][6];
  logic [QW-1:0]    qq_q [QW][6];
  logic [LW-1:0]    qr_d [QW][6];
  logic [QW-1:0]    ql_d [QW][6];
  logic [QW-1:0]    qq_d [QW][6];

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      len_dp[v] = (sr_q[LW-1][v][LW-1:0] == '0) ? LW'(1) : sr_q[LW-1][v][LW-1:0];
    end
    for (int j = 0; j < 6; j++) begin
      dvd_dp[j] = {1'b0, svm_q[LW-1][j], {UB{1'b0}}}
                + (UB+MW+1)'(len_dp[(j < 3) ? 0 : 1] >> 1);
    end
  end

  always_comb begin
    logic [LW:0]   tin;
    logic [LW-1:0] rin;
    logic [QW-1:0] lin;
    logic [QW-1:0] qin;
    logic [LW-1:0] din;
    for (int t = 0; t < QW; t++) begin
      for (int j = 0; j < 6; j++) begin
        rin = (t == 0) ? drem_q[j] : qr_q[(t == 0) ? 0 : t-1][j];
        lin = (t == 0) ? dlo_q[j] : ql_q[(t == 0) ? 0 : t-1][j];
        qin = (t == 0) ? '0 : qq_q[(t == 0) ? 0 : t-1][j];
        din = (t == 0) ? dl_q[(j < 3) ? 0 : 1] : qd_q[(t == 0) ? 0 : t-1][(j < 3) ? 0 : 1];
        tin = {rin, lin[QW-1]};
        ql_d[t][j] = lin << 1;
        if (tin >= {1'b0, din}) begin
          qr_d[t][j] = LW'(tin - {1'b0, din});
          qq_d[t][j] = {qin[QW-2:0], 1'b1};
        end else begin
          qr_d[t][j] = tin[LW-1:0];
          qq_d[t][j] = {qin[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 2; v++) dl_q[v] <= len_dp[v];
      for (int j = 0; j < 6; j++) begin
        drem_q[j] <= LW'(dvd_dp[j][UB+MW:QW]);
        dlo_q[j]  <= dvd_dp[j][QW-1:0];
      end
      for (int t = 0; t < QW; t++) begin
        for (int v = 0; v < 2; v++) begin
          qd_q[t][v] <= (t == 0) ? dl_q[v] : qd_q[(t == 0) ? 0 : t-1][v];
        end
        for (int j = 0; j < 6; j++) begin
          qr_q[t][j] <= qr_d[t][j];
          ql_q[t][j] <= ql_d[t][j];
          qq_q[t][j] <= qq_d[t][j];
        end
      end
    end
  end

  // scale to radius, merge offsets, grow and saturate
  logic [RHW+QW-1:0] ma_q [6];
  logic [UB+QW-1:0]  mb_q [6];
  logic [OW-1:0]     of_q [6];
  logic [OW-1:0]     om_q [3];
  logic [CW-1:0]     mn_q [3];
  logic [CW-1:0]     mx_q [3];
  logic              zr_q;
  logic [UB+QW:0]    rnd [6];
  side_t             sd_ml;
  side_t             sd_of;
  side_t             sd_om;

  assign sd_ml = sd_q[ML-1];
  assign sd_of = sd_q[ML+1];
  assign sd_om = sd_q[ML+2];

  always_comb begin
    for (int j = 0; j < 6; j++) rnd[j] = {1'b0, mb_q[j]} + ((UB+QW+1)'(1) << (UB - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        ma_q[j] <= (RHW+QW)'(sd_ml.rad[RW-1:UB]) * (RHW+QW)'(qq_q[QW-1][j]);
        mb_q[j] <= (UB+QW)'(sd_ml.rad[UB-1:0]) * (UB+QW)'(qq_q[QW-1][j]);
        of_q[j] <= OW'(ma_q[j]) + OW'(rnd[j][UB+QW:UB]);
      end
      for (int c = 0; c < 3; c++) begin
        if (sd_of.zero) om_q[c] <= '0;
        else om_q[c] <= (of_q[c] > of_q[3+c]) ? of_q[c] : of_q[3+c];
        mn_q[c] <= sat($signed({{2{sd_om.lo[c][CW-1]}}, sd_om.lo[c]}) - $signed({1'b0, om_q[c]}));
        mx_q[c] <= sat($signed({{2{sd_om.hi[c][CW-1]}}, sd_om.hi[c]}) + $signed({1'b0, om_q[c]}));
      end
      zr_q <= sd_om.zero;
    end
  end

  assign min_x_o     = mn_q[0];
  assign min_y_o     = mn_q[1];
  assign min_z_o     = mn_q[2];
  assign max_x_o     = mx_q[0];
  assign max_y_o     = mx_q[1];
  assign max_z_o     = mx_q[2];
  assign zero_axis_o = zr_q;

endmodule

// ===== sv/cbb_checker.sv =====
// ----------------------------------------------------------------------------
// cbb_checker
// Port-level checks for the cylinder bounding box unit, bound to the top level.
// ----------------------------------------------------------------------------
module cbb_checker
  import cbb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic signed [CW-1:0] start_x_i,
  input logic signed [CW-1:0] start_y_i,
  input logic signed [CW-1:0] start_z_i,
  input logic signed [CW-1:0] end_x_i,
  input logic signed [CW-1:0] end_y_i,
  input logic signed [CW-1:0] end_z_i,
  input logic [RW-1:0]        cyl_radius_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [CW-1:0] min_x_o,
  input logic signed [CW-1:0] min_y_o,
  input logic signed [CW-1:0] min_z_o,
  input logic signed [CW-1:0] max_x_o,
  input logic signed [CW-1:0] max_y_o,
  input logic signed [CW-1:0] max_z_o,
  input logic                 zero_axis_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(min_x_o) && $stable(max_z_o))
    else $error("item changed while stalled");

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_x_o <= max_x_o) && (min_y_o <= max_y_o) && (min_z_o <= max_z_o))
    else $error("box minimum above maximum");

  a_zero_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_axis_o |->
      (min_x_o == max_x_o) && (min_y_o == max_y_o) && (min_z_o == max_z_o))
    else $error("zero axis box not a single point");

endmodule

bind cylinder_bounding_box_unit cbb_checker u_cbb_checker (.*);
